/* src/dmwc_pkg.sv */
package dmwc_pkg;

  localparam int ADDR_W       = 32;
  localparam int TAG_W        = 27;
  localparam int SEL_W        = 4;
  localparam int CMD_W        = 2;
  localparam int LC_W         = 4;
  localparam int LINE_INDEX_W = 10;
  localparam int CYCLES_W     = 8;
  localparam int CNT_W        = 32;
  localparam int NUM_CNT      = 10;
  localparam int QUEUE_DEPTH  = 2;

  localparam logic [LC_W-1:0] LC_RESET = 4'd10;

  localparam int FILL_LATENCY = 80;
  localparam logic [CYCLES_W-1:0] CYC_HIT   = 8'd1;
  localparam logic [CYCLES_W-1:0] CYC_CLEAN = 8'(1 + FILL_LATENCY);
  localparam logic [CYCLES_W-1:0] CYC_DIRTY = 8'(1 + 2 * FILL_LATENCY);

  typedef enum logic [CMD_W-1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_STAT  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  localparam logic [1:0] OUT_HIT   = 2'd0;
  localparam logic [1:0] OUT_CLEAN = 2'd1;
  localparam logic [1:0] OUT_DIRTY = 2'd2;

  localparam logic [SEL_W-1:0] CNT_RD     = 4'd0;
  localparam logic [SEL_W-1:0] CNT_WR     = 4'd1;
  localparam logic [SEL_W-1:0] CNT_RMISS  = 4'd2;
  localparam logic [SEL_W-1:0] CNT_WMISS  = 4'd3;
  localparam logic [SEL_W-1:0] CNT_DRMISS = 4'd4;
  localparam logic [SEL_W-1:0] CNT_DWMISS = 4'd5;
  localparam logic [SEL_W-1:0] CNT_BRD    = 4'd6;
  localparam logic [SEL_W-1:0] CNT_BWR    = 4'd7;
  localparam logic [SEL_W-1:0] CNT_RTIME  = 4'd8;
  localparam logic [SEL_W-1:0] CNT_WTIME  = 4'd9;

  typedef struct packed {
    cmd_e                   cmd;
    logic [SEL_W-1:0]       sel;
    logic [TAG_W-1:0]       tag;
  } req_t;

endpackage

/* src/dmwc_ram.sv */
module dmwc_ram #(
  parameter int WIDTH = 29,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* src/dmwc_back.sv */
module dmwc_back import dmwc_pkg::*; #(
  parameter int MAX_LINES_LOG2 = 10,
  parameter int BLOCK_BYTES    = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      q_empty_i,
  input  req_t                      q_req_i,
  input  logic [MAX_LINES_LOG2-1:0] q_idx_i,
  output logic                      q_pop_o,
  output logic                      clearing_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic                      hit_o,
  output logic [1:0]                outcome_o,
  output logic [LINE_INDEX_W-1:0]   line_index_o,
  output logic [TAG_W-1:0]          access_tag_o,
  output logic                      prev_valid_o,
  output logic [TAG_W-1:0]          prev_tag_o,
  output logic                      prev_dirty_o,
  output logic [CYCLES_W-1:0]       access_cycles_o,
  output logic [CNT_W-1:0]          counter_value_o
);

  localparam int IW        = MAX_LINES_LOG2;
  localparam int NUM_LINES = 1 << MAX_LINES_LOG2;
  localparam int ENTRY_W   = TAG_W + 2;

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_EVAL  = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [IW-1:0]    clr_q, clr_d;
  req_t             cur_q;
  logic [IW-1:0]    cur_idx_q;
  logic [CNT_W-1:0] cnt_q [NUM_CNT];
  logic [CNT_W-1:0] cnt_d [NUM_CNT];

  logic                ram_we, ram_re;
  logic [IW-1:0]       ram_waddr;
  logic [ENTRY_W-1:0]  ram_wdata, ram_rdata;

  logic                is_acc, is_rd, pv, pd, hit, dirty_miss, fire, new_dirty;
  logic [TAG_W-1:0]    pt;
  logic [CYCLES_W-1:0] cycles;
  logic [1:0]          outcome;

  logic                out_valid_q, hit_q, pv_q, pd_q;
  logic [1:0]          outcome_q;
  logic [LINE_INDEX_W-1:0] line_index_q;
  logic [TAG_W-1:0]    access_tag_q, prev_tag_q;
  logic [CYCLES_W-1:0] cycles_q;
  logic [CNT_W-1:0]    counter_value_q;

  dmwc_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(NUM_LINES)
  ) u_tag_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(q_idx_i),
    .rdata_o(ram_rdata)
  );

  assign is_acc     = (cur_q.cmd == CMD_READ) || (cur_q.cmd == CMD_WRITE);
  assign is_rd      = (cur_q.cmd == CMD_READ);
  assign pv         = ram_rdata[ENTRY_W-1];
  assign pd         = ram_rdata[ENTRY_W-2];
  assign pt         = ram_rdata[TAG_W-1:0];
  assign hit        = pv && (pt == cur_q.tag);
  assign dirty_miss = !hit && pv && pd;
  assign new_dirty  = hit ? (pd || !is_rd) : !is_rd;
  assign cycles     = hit ? CYC_HIT : (dirty_miss ? CYC_DIRTY : CYC_CLEAN);
  assign outcome    = hit ? OUT_HIT : (dirty_miss ? OUT_DIRTY : OUT_CLEAN);

  assign fire       = (state_q == S_EVAL) && (!out_valid_q || out_ready_i);
  assign q_pop_o    = (state_q == S_IDLE) && !q_empty_i;
  assign ram_re     = q_pop_o;
  assign ram_we     = (state_q == S_CLEAR) || (fire && is_acc);
  assign ram_waddr  = (state_q == S_CLEAR) ? clr_q : cur_idx_q;
  assign ram_wdata  = (state_q == S_CLEAR) ? '0 : {1'b1, new_dirty, cur_q.tag};
  assign clearing_o = (state_q == S_CLEAR);

  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    unique case (state_q)
      S_CLEAR: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == {IW{1'b1}}) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (!q_empty_i) begin
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        if (fire) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    for (int i = 0; i < NUM_CNT; i++) begin
      cnt_d[i] = cnt_q[i];
    end
    if (fire && is_acc) begin
      cnt_d[is_rd ? CNT_RD : CNT_WR] = cnt_q[is_rd ? CNT_RD : CNT_WR] + 1'b1;
      if (!hit) begin
        cnt_d[is_rd ? CNT_RMISS : CNT_WMISS] = cnt_q[is_rd ? CNT_RMISS : CNT_WMISS] + 1'b1;
        cnt_d[CNT_BRD] = cnt_q[CNT_BRD] + CNT_W'(BLOCK_BYTES);
        if (dirty_miss) begin
          cnt_d[is_rd ? CNT_DRMISS : CNT_DWMISS] =
            cnt_q[is_rd ? CNT_DRMISS : CNT_DWMISS] + 1'b1;
          cnt_d[CNT_BWR] = cnt_q[CNT_BWR] + CNT_W'(BLOCK_BYTES);
        end
      end
      cnt_d[is_rd ? CNT_RTIME : CNT_WTIME] =
        cnt_q[is_rd ? CNT_RTIME : CNT_WTIME] + CNT_W'(cycles);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NUM_CNT; i++) begin
        cnt_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      for (int i = 0; i < NUM_CNT; i++) begin
        cnt_q[i] <= cnt_d[i];
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      cur_q     <= q_req_i;
      cur_idx_q <= q_idx_i;
    end
    if (fire) begin
      hit_q           <= 1'b0;
      outcome_q       <= OUT_HIT;
      line_index_q    <= '0;
      access_tag_q    <= '0;
      pv_q            <= 1'b0;
      prev_tag_q      <= '0;
      pd_q            <= 1'b0;
      cycles_q        <= '0;
      counter_value_q <= '0;
      case (cur_q.cmd) inside
        CMD_READ, CMD_WRITE: begin
          hit_q        <= hit;
          outcome_q    <= outcome;
          line_index_q <= LINE_INDEX_W'(32'(cur_idx_q));
          access_tag_q <= cur_q.tag;
          pv_q         <= pv;
          prev_tag_q   <= pv ? pt : '0;
          pd_q         <= pd;
          cycles_q     <= cycles;
        end
        CMD_STAT: begin
          if (cur_q.sel < SEL_W'(NUM_CNT)) begin
            counter_value_q <= cnt_q[cur_q.sel];
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign hit_o           = hit_q;
  assign outcome_o       = outcome_q;
  assign line_index_o    = line_index_q;
  assign access_tag_o    = access_tag_q;
  assign prev_valid_o    = pv_q;
  assign prev_tag_o      = prev_tag_q;
  assign prev_dirty_o    = pd_q;
  assign access_cycles_o = cycles_q;
  assign counter_value_o = counter_value_q;

endmodule

/* src/dmwc_front.sv */
module dmwc_front import dmwc_pkg::*; #(
  parameter int MAX_LINES_LOG2 = 10,
  parameter int BLOCK_BYTES    = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [LC_W-1:0]           cfg_line_count_log2_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [CMD_W-1:0]          command_i,
  input  logic [ADDR_W-1:0]         mem_address_i,
  input  logic [SEL_W-1:0]          counter_select_i,
  input  logic                      q_full_i,
  input  logic                      clearing_i,
  output logic                      push_o,
  output req_t                      push_req_o,
  output logic [MAX_LINES_LOG2-1:0] push_idx_o
);

  localparam int OFF_W = $clog2(BLOCK_BYTES);

  logic [LC_W-1:0]   lc_q;
  logic [4:0]        lc_ext, ib;
  logic [5:0]        low;
  logic [ADDR_W-1:0] idx_full, idx_mask;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lc_q <= LC_RESET;
    end else if (cfg_valid_i) begin
      lc_q <= cfg_line_count_log2_i;
    end
  end

  assign cfg_ready_o = 1'b1;

  always_comb begin
    lc_ext = {1'b0, lc_q};
    if (lc_ext < 5'd1) begin
      ib = 5'd1;
    end else if (lc_ext > 5'(MAX_LINES_LOG2)) begin
      ib = 5'(MAX_LINES_LOG2);
    end else begin
      ib = lc_ext;
    end
  end

  assign low      = 6'(OFF_W) + {1'b0, ib};
  assign idx_full = mem_address_i >> OFF_W;
  assign idx_mask = ~({ADDR_W{1'b1}} << ib);

  assign in_ready_o      = !q_full_i && !clearing_i;
  assign push_o          = in_valid_i && in_ready_o;
  assign push_req_o.cmd  = cmd_e'(command_i);
  assign push_req_o.sel  = counter_select_i;
  assign push_req_o.tag  = TAG_W'(mem_address_i >> low);
  assign push_idx_o      = MAX_LINES_LOG2'(idx_full & idx_mask);

endmodule

/* src/dmwc_queue.sv */
module dmwc_queue import dmwc_pkg::*; #(
  parameter int IW = 10
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  req_t          push_req_i,
  input  logic [IW-1:0] push_idx_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output req_t          head_req_o,
  output logic [IW-1:0] head_idx_o
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

  req_t              req_q [QUEUE_DEPTH];
  logic [IW-1:0]     idx_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CNT_QW-1:0] count_q;

  assign full_o     = (count_q == CNT_QW'(QUEUE_DEPTH));
  assign empty_o    = (count_q == '0);
  assign head_req_o = req_q[rd_ptr_q];
  assign head_idx_o = idx_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      req_q[wr_ptr_q] <= push_req_i;
      idx_q[wr_ptr_q] <= push_idx_i;
    end
  end

endmodule

/* src/direct_mapped_writeback_cache.sv */
// Channel   Handshake                      Payload
// cfg       cfg_valid_i / cfg_ready_o      cfg_line_count_log2_i
// in        in_valid_i  / in_ready_o       command_i, mem_address_i, counter_select_i
// out       out_valid_o / out_ready_i      hit_o .. counter_value_o
//
// In the back end each request goes through a tag RAM read, then evaluate and write back.
// An accepted request passes the queue and the tag RAM read register before the output register.
// After reset a clearing pass writes every tag RAM line, all 2**MAX_LINES_LOG2 of them
// (1024 by default); in_ready_o is low until it ends, cfg writes are taken throughout.
// A two-entry queue holds accepted requests while the output register waits on out_ready_i.
module direct_mapped_writeback_cache import dmwc_pkg::*; #(
  parameter int MAX_LINES_LOG2 = 10,
  parameter int BLOCK_BYTES    = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [LC_W-1:0]         cfg_line_count_log2_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [CMD_W-1:0]        command_i,
  input  logic [ADDR_W-1:0]       mem_address_i,
  input  logic [SEL_W-1:0]        counter_select_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic                    hit_o,
  output logic [1:0]              outcome_o,
  output logic [LINE_INDEX_W-1:0] line_index_o,
  output logic [TAG_W-1:0]        access_tag_o,
  output logic                    prev_valid_o,
  output logic [TAG_W-1:0]        prev_tag_o,
  output logic                    prev_dirty_o,
  output logic [CYCLES_W-1:0]     access_cycles_o,
  output logic [CNT_W-1:0]        counter_value_o
);

  logic                      push, q_full, q_empty, q_pop, clearing;
  req_t                      push_req, head_req;
  logic [MAX_LINES_LOG2-1:0] push_idx, head_idx;

  dmwc_front #(
    .MAX_LINES_LOG2(MAX_LINES_LOG2),
    .BLOCK_BYTES   (BLOCK_BYTES)
  ) u_front (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_valid_i          (cfg_valid_i),
    .cfg_ready_o          (cfg_ready_o),
    .cfg_line_count_log2_i(cfg_line_count_log2_i),
    .in_valid_i           (in_valid_i),
    .in_ready_o           (in_ready_o),
    .command_i            (command_i),
    .mem_address_i        (mem_address_i),
    .counter_select_i     (counter_select_i),
    .q_full_i             (q_full),
    .clearing_i           (clearing),
    .push_o               (push),
    .push_req_o           (push_req),
    .push_idx_o           (push_idx)
  );

  dmwc_queue #(
    .IW(MAX_LINES_LOG2)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_req_i(push_req),
    .push_idx_i(push_idx),
    .full_o    (q_full),
    .pop_i     (q_pop),
    .empty_o   (q_empty),
    .head_req_o(head_req),
    .head_idx_o(head_idx)
  );

  dmwc_back #(
    .MAX_LINES_LOG2(MAX_LINES_LOG2),
    .BLOCK_BYTES   (BLOCK_BYTES)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_empty_i      (q_empty),
    .q_req_i        (head_req),
    .q_idx_i        (head_idx),
    .q_pop_o        (q_pop),
    .clearing_o     (clearing),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .hit_o          (hit_o),
    .outcome_o      (outcome_o),
    .line_index_o   (line_index_o),
    .access_tag_o   (access_tag_o),
    .prev_valid_o   (prev_valid_o),
    .prev_tag_o     (prev_tag_o),
    .prev_dirty_o   (prev_dirty_o),
    .access_cycles_o(access_cycles_o),
    .counter_value_o(counter_value_o)
  );

  a_no_accept_while_clearing: assert property (
    @(posedge clk_i) disable iff (!rst_ni) clearing |-> !in_ready_o
  ) else $error("request accepted during tag clearing pass");

  a_hit_timing: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && hit_o) |-> (outcome_o == OUT_HIT && access_cycles_o == CYC_HIT)
  ) else $error("hit reported with wrong outcome or time");

  a_dirty_miss_source: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && outcome_o == OUT_DIRTY) |-> (prev_valid_o && prev_dirty_o && !hit_o)
  ) else $error("dirty miss on a line that was not valid and dirty");

  a_invalid_prev_tag: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !prev_valid_o) |-> (prev_tag_o == '0 && !hit_o)
  ) else $error("invalid line reported a tag or a hit");

endmodule
